// ----- hdl/tshc_pkg.sv -----
// ----------------------------------------------------------------------------
// tshc_pkg
// Shared widths, operation codes and the entry layout of the score cache.
// ----------------------------------------------------------------------------
package tshc_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int KEY_W             = 64;
    localparam int SCORE_W           = 32;
    localparam int OP_W              = 2;
    localparam int DIGIT_W           = 4;

    localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] first;
        logic signed [SCORE_W-1:0] second;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/tshc_ram.sv -----
// ----------------------------------------------------------------------------
// tshc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tshc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tshc_home.sv -----
// ----------------------------------------------------------------------------
// tshc_home
// Home slot of a key: key modulo TABLE_ENTRIES. Power-of-two tables take the
// low bits into a register; other sizes reduce one 4-bit digit per cycle.
// ----------------------------------------------------------------------------
module tshc_home #(
    parameter int TABLE_ENTRIES = tshc_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tshc_pkg::KEY_W-1:0]  key,
    output logic                        done,
    output logic [IDX_W-1:0]            home
);

    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= key[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
        else
        begin : g_serial
            localparam int DW     = tshc_pkg::DIGIT_W;
            localparam int DIGITS = tshc_pkg::KEY_W / DW;
            localparam int CNT_W  = $clog2(DIGITS);
            localparam int T_W    = IDX_W + DW;
            localparam logic [T_W-1:0] MOD_N = T_W'(TABLE_ENTRIES);

            logic                       run_reg;
            logic                       done_reg;
            logic [CNT_W-1:0]           cnt_reg;
            logic [tshc_pkg::KEY_W-1:0] key_sh_reg;
            logic [IDX_W-1:0]           rem_reg;
            logic [T_W-1:0]             rem_next;

            always_comb
            begin
                logic [T_W-1:0] t;
                t = {rem_reg, key_sh_reg[tshc_pkg::KEY_W-1 -: DW]};
                for (int j = DW - 1; j >= 0; j--)
                begin
                    if (t >= (MOD_N << j))
                    begin
                        t = t - (MOD_N << j);
                    end
                end
                rem_next = t;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        run_reg <= 1'b1;
                        cnt_reg <= '0;
                    end
                    else if (run_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_W'(DIGITS - 1))
                        begin
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    key_sh_reg <= key;
                    rem_reg    <= '0;
                end
                else if (run_reg)
                begin
                    key_sh_reg <= key_sh_reg << DW;
                    rem_reg    <= rem_next[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate

endmodule

// ----- hdl/two_slot_hash_score_cache.sv -----
// ----------------------------------------------------------------------------
// two_slot_hash_score_cache
// Probe/store/clear of a two-slot hash cache of 64-bit keys with two scores.
// Probe and store pass the key-modulo unit, then the home and neighbour reads,
// then the decide state; one item at a time. A reserved op returns done, no hit.
// Clear sweeps the entry RAM one entry a cycle.
// After reset the same sweep runs with busy high.
// The result sits on the outputs for one cycle with done; it cannot stall.
// ----------------------------------------------------------------------------
module two_slot_hash_score_cache #(
    parameter int TABLE_ENTRIES = tshc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [tshc_pkg::OP_W-1:0]             op,
    input  logic [tshc_pkg::KEY_W-1:0]            key,
    input  logic signed [tshc_pkg::SCORE_W-1:0]   mg_score,
    input  logic signed [tshc_pkg::SCORE_W-1:0]   eg_score,
    output logic                                  done,
    output logic                                  hit,
    output logic signed [tshc_pkg::SCORE_W-1:0]   mg_found,
    output logic signed [tshc_pkg::SCORE_W-1:0]   eg_found
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int KW    = tshc_pkg::KEY_W;
    localparam int SW    = tshc_pkg::SCORE_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RDN  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  clr_op_reg, clr_op_next;
    logic [tshc_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]         key_reg;
    logic signed [SW-1:0]  mg_reg, eg_reg;
    logic [IDX_W-1:0]      home_reg;
    tshc_pkg::entry_t      slot_h_reg;

    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic signed [SW-1:0]  mg_found_reg, mg_found_next;
    logic signed [SW-1:0]  eg_found_reg, eg_found_next;

    logic                  accept;
    logic                  hash_start, hash_done;
    logic [IDX_W-1:0]      hash_home;
    logic [IDX_W-1:0]      nbr;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    tshc_pkg::entry_t      ram_wdata, ram_rdata;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign hash_start = accept && (op == tshc_pkg::OP_PROBE || op == tshc_pkg::OP_STORE);

    tshc_home #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .home  (hash_home)
    );

    tshc_ram #(
        .WIDTH (tshc_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nbr = (home_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : home_reg + 1'b1;
    assign ram_raddr = (state_reg == S_RDN) ? nbr : hash_home;

    always_comb
    begin
        logic h_match, n_match;
        h_match = (slot_h_reg.key == key_reg);
        n_match = (ram_rdata.key == key_reg);

        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_op_next   = clr_op_reg;
        done_next     = 1'b0;
        hit_next      = 1'b0;
        mg_found_next = '0;
        eg_found_next = '0;
        ram_we        = 1'b0;
        ram_waddr     = clr_cnt_reg;
        ram_wdata     = '0;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                    done_next    = clr_op_reg;
                    clr_op_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op) inside
                        tshc_pkg::OP_PROBE, tshc_pkg::OP_STORE:
                        begin
                            state_next = S_HASH;
                        end
                        tshc_pkg::OP_CLEAR:
                        begin
                            state_next   = S_CLR;
                            clr_cnt_next = '0;
                            clr_op_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_RDN;
                end
            end
            S_RDN:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (op_reg == tshc_pkg::OP_PROBE)
                begin
                    if (h_match)
                    begin
                        hit_next      = 1'b1;
                        mg_found_next = slot_h_reg.first;
                        eg_found_next = slot_h_reg.second;
                    end
                    else if (n_match)
                    begin
                        hit_next      = 1'b1;
                        mg_found_next = ram_rdata.first;
                        eg_found_next = ram_rdata.second;
                    end
                end
                else
                begin
                    ram_wdata.key    = key_reg;
                    ram_wdata.first  = mg_reg;
                    ram_wdata.second = eg_reg;
                    if (h_match || n_match)
                    begin
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (slot_h_reg.key != '0 && ram_rdata.key == '0)
                        begin
                            ram_waddr = nbr;
                        end
                        else
                        begin
                            ram_waddr = home_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= key;
            mg_reg  <= mg_score;
            eg_reg  <= eg_score;
        end
        if (state_reg == S_HASH && hash_done)
        begin
            home_reg <= hash_home;
        end
        if (state_reg == S_RDN)
        begin
            slot_h_reg <= ram_rdata;
        end
        hit_reg      <= hit_next;
        mg_found_reg <= mg_found_next;
        eg_found_reg <= eg_found_next;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign mg_found = mg_found_reg;
    assign eg_found = eg_found_reg;

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLR || state_reg == S_DEC))
        else $error("entry write outside sweep or decide");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> ($past(state_reg) == S_DEC || $past(state_reg) == S_CLR
                             || $past(state_reg) == S_IDLE))
        else $error("result without a finished item");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !hit_reg) |-> (mg_found_reg == '0 && eg_found_reg == '0))
        else $error("nonzero scores on a miss");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op != tshc_pkg::OP_RSVD) |=> busy)
        else $error("item accepted but block not busy");

endmodule
